// ----- hdl/gms_pkg.sv -----
// gms_pkg: shared types and constants of the grab motion sequencer
// result item layout, register block, step, action and command codes
// no dependencies
`default_nettype none

package gms_pkg;

  // command codes carried by an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_ESTOP = 2'd2;
  localparam logic [1:0] CMD_HOME  = 2'd3;

  // action codes of a result item
  localparam logic [2:0] ACT_MOVE = 3'd0;
  localparam logic [2:0] ACT_BON  = 3'd1;
  localparam logic [2:0] ACT_BOFF = 3'd2;
  localparam logic [2:0] ACT_DONE = 3'd3;
  localparam logic [2:0] ACT_ZERO = 3'd4;

  // axis codes
  localparam logic [1:0] AXIS_NONE  = 2'd0;
  localparam logic [1:0] AXIS_HORIZ = 2'd1;
  localparam logic [1:0] AXIS_VERT  = 2'd2;

  // sequence step codes
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_ESTOP      = 4'd1;
  localparam logic [3:0] ST_HOME       = 4'd2;
  localparam logic [3:0] ST_LONG_DROP  = 4'd3;
  localparam logic [3:0] ST_BRUSH_ON   = 4'd4;
  localparam logic [3:0] ST_SWEEP_F1   = 4'd5;
  localparam logic [3:0] ST_DROP_1     = 4'd6;
  localparam logic [3:0] ST_SWEEP_R1   = 4'd7;
  localparam logic [3:0] ST_DROP_2     = 4'd8;
  localparam logic [3:0] ST_SWEEP_F2   = 4'd9;
  localparam logic [3:0] ST_DROP_3     = 4'd10;
  localparam logic [3:0] ST_SWEEP_R2   = 4'd11;
  localparam logic [3:0] ST_BRUSH_OFF  = 4'd12;
  localparam logic [3:0] ST_RISE       = 4'd13;

  // register indexes
  localparam logic [2:0] REG_SWEEP_PULSES      = 3'd0;
  localparam logic [2:0] REG_LONG_DROP_PULSES  = 3'd1;
  localparam logic [2:0] REG_SHORT_DROP_PULSES = 3'd2;
  localparam logic [2:0] REG_RISE_PULSES       = 3'd3;
  localparam logic [2:0] REG_SWEEP_SPEED       = 3'd4;
  localparam logic [2:0] REG_VERTICAL_SPEED    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT_TICKS     = 3'd6;
  localparam logic [2:0] REG_HOME_OFFSET       = 3'd7;

  // register reset values
  localparam logic [23:0] RST_SWEEP_PULSES      = 24'd6472;
  localparam logic [23:0] RST_LONG_DROP_PULSES  = 24'd160000;
  localparam logic [23:0] RST_SHORT_DROP_PULSES = 24'd16000;
  localparam logic [23:0] RST_RISE_PULSES       = 24'd208000;
  localparam logic [12:0] RST_SWEEP_SPEED       = 13'd50;
  localparam logic [12:0] RST_VERTICAL_SPEED    = 13'd500;
  localparam logic [15:0] RST_TIMEOUT_TICKS     = 16'd30000;
  localparam logic [23:0] RST_HOME_OFFSET       = 24'd0;

  // fixed move constants
  localparam logic [7:0]  MOVE_ACCEL   = 8'd100;
  localparam logic [12:0] HOME_H_SPEED = 13'd200;
  localparam logic [6:0]  BRUSH_DUTY   = 7'd100;

  typedef struct packed {
    logic [23:0] sweep_pulses;
    logic [23:0] long_drop_pulses;
    logic [23:0] short_drop_pulses;
    logic [23:0] rise_pulses;
    logic [12:0] sweep_speed;
    logic [12:0] vertical_speed;
    logic [15:0] timeout_ticks;
    logic [23:0] home_offset;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  axis;
    logic        direction;
    logic [12:0] speed;
    logic [7:0]  acceleration;
    logic [23:0] pulses;
    logic        absolute;
    logic [6:0]  brush_duty;
    logic        last;
    logic [3:0]  step_now;
  } result_t;

  // up to three results produced by one item, pushed together
  typedef struct packed {
    logic [1:0]        num;
    result_t [2:0]     res;
  } push_t;

endpackage

`default_nettype wire

// ----- hdl/grab_motion_sequencer.sv -----
// grab_motion_sequencer: top level, input register, step logic, result queue, registers
// path: an item is held in the input register, then its results are written into the result
// queue, whose head drives the output.
// throughput: one item per cycle while the result queue holds at most one entry; an item
// gives up to 3 results, one per cycle while out_stall is low.
// reset: synchronous active-low rst_n returns the step to idle, clears the queue and
// restores every register to its default
`default_nettype none

module grab_motion_sequencer
  import gms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic        in_horiz_arrived,
  input  wire logic        in_vert_arrived,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  out_action,
  output logic      [1:0]  out_axis,
  output logic             out_direction,
  output logic      [12:0] out_speed,
  output logic      [7:0]  out_acceleration,
  output logic      [23:0] out_pulses,
  output logic             out_absolute,
  output logic      [6:0]  out_brush_duty,
  output logic             out_last,
  output logic      [3:0]  out_step_now,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t        cfg;
  push_t       push;
  result_t     head;
  logic        room3;
  logic        fire;
  logic        accept;

  // input register: holds one item until the queue has room for all its results
  logic        in_valid_r;
  logic [1:0]  cmd_r;
  logic        h_r;
  logic        v_r;

  assign fire     = in_valid_r && room3;
  assign in_stall = in_valid_r && !room3;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept || fire) begin
      in_valid_r <= accept;
    end
  end

  // payload only loads on an accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      h_r   <= in_horiz_arrived;
      v_r   <= in_vert_arrived;
    end
  end

  gms_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequence state and the results of the registered item, in one pass
  gms_step_logic u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .command       (cmd_r),
    .horiz_arrived (h_r),
    .vert_arrived  (v_r),
    .cfg           (cfg),
    .push          (push)
  );

  // results wait here so the input side keeps moving while the output stalls, until the queue fills
  gms_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .pop       (!out_stall),
    .not_empty (out_valid),
    .room3     (room3),
    .head      (head)
  );

  assign out_action       = head.action;
  assign out_axis         = head.axis;
  assign out_direction    = head.direction;
  assign out_speed        = head.speed;
  assign out_acceleration = head.acceleration;
  assign out_pulses       = head.pulses;
  assign out_absolute     = head.absolute;
  assign out_brush_duty   = head.brush_duty;
  assign out_last         = head.last;
  assign out_step_now     = head.step_now;

endmodule

`default_nettype wire

// ----- hdl/gms_cfg_regs.sv -----
// gms_cfg_regs: apb-style register block of the grab motion sequencer
// depends on gms_pkg for cfg_t, register indexes and reset values
`default_nettype none

module gms_cfg_regs
  import gms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SWEEP_PULSES:      cfg_nxt.sweep_pulses      = pwdata[23:0];
        REG_LONG_DROP_PULSES:  cfg_nxt.long_drop_pulses  = pwdata[23:0];
        REG_SHORT_DROP_PULSES: cfg_nxt.short_drop_pulses = pwdata[23:0];
        REG_RISE_PULSES:       cfg_nxt.rise_pulses       = pwdata[23:0];
        REG_SWEEP_SPEED:       cfg_nxt.sweep_speed       = pwdata[12:0];
        REG_VERTICAL_SPEED:    cfg_nxt.vertical_speed    = pwdata[12:0];
        REG_TIMEOUT_TICKS:     cfg_nxt.timeout_ticks     = pwdata[15:0];
        REG_HOME_OFFSET:       cfg_nxt.home_offset       = pwdata[23:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SWEEP_PULSES:      prdata = {8'd0, cfg_r.sweep_pulses};
      REG_LONG_DROP_PULSES:  prdata = {8'd0, cfg_r.long_drop_pulses};
      REG_SHORT_DROP_PULSES: prdata = {8'd0, cfg_r.short_drop_pulses};
      REG_RISE_PULSES:       prdata = {8'd0, cfg_r.rise_pulses};
      REG_SWEEP_SPEED:       prdata = {19'd0, cfg_r.sweep_speed};
      REG_VERTICAL_SPEED:    prdata = {19'd0, cfg_r.vertical_speed};
      REG_TIMEOUT_TICKS:     prdata = {16'd0, cfg_r.timeout_ticks};
      REG_HOME_OFFSET:       prdata = {8'd0, cfg_r.home_offset};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sweep_pulses      <= RST_SWEEP_PULSES;
      cfg_r.long_drop_pulses  <= RST_LONG_DROP_PULSES;
      cfg_r.short_drop_pulses <= RST_SHORT_DROP_PULSES;
      cfg_r.rise_pulses       <= RST_RISE_PULSES;
      cfg_r.sweep_speed       <= RST_SWEEP_SPEED;
      cfg_r.vertical_speed    <= RST_VERTICAL_SPEED;
      cfg_r.timeout_ticks     <= RST_TIMEOUT_TICKS;
      cfg_r.home_offset       <= RST_HOME_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gms_step_logic.sv -----
// gms_step_logic: step register, arrival tracking, timeout count and result build
// depends on gms_pkg for cfg_t, push_t and the step and action codes
`default_nettype none

module gms_step_logic
  import gms_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [1:0] command,
  input  wire logic       horiz_arrived,
  input  wire logic       vert_arrived,
  input  wire cfg_t       cfg,
  output push_t           push
);

  logic [3:0]  step_r;
  logic [3:0]  step_nxt;
  logic [1:0]  seen_r;
  logic [1:0]  seen_nxt;
  logic [15:0] ticks_r;
  logic [15:0] ticks_nxt;

  function automatic result_t mk(logic [2:0] act, logic [1:0] ax, logic dir,
                                 logic [12:0] spd, logic [7:0] acc, logic [23:0] pul,
                                 logic ab, logic [6:0] duty);
    result_t r;
    r.action       = act;
    r.axis         = ax;
    r.direction    = dir;
    r.speed        = spd;
    r.acceleration = acc;
    r.pulses       = pul;
    r.absolute     = ab;
    r.brush_duty   = duty;
    r.last         = 1'b0;
    r.step_now     = ST_IDLE;
    return r;
  endfunction

  // command issued on entry to a sequence step
  function automatic result_t issue(logic [3:0] s, cfg_t c);
    result_t r;
    r = mk(ACT_BOFF, AXIS_NONE, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, 7'd0);
    case (s)
      ST_LONG_DROP:
        r = mk(ACT_MOVE, AXIS_VERT, 1'b1, c.vertical_speed, MOVE_ACCEL,
               c.long_drop_pulses, 1'b0, 7'd0);
      ST_BRUSH_ON:
        r = mk(ACT_BON, AXIS_NONE, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, BRUSH_DUTY);
      ST_SWEEP_F1, ST_SWEEP_F2:
        r = mk(ACT_MOVE, AXIS_HORIZ, 1'b0, c.sweep_speed, MOVE_ACCEL,
               c.sweep_pulses, 1'b0, 7'd0);
      ST_SWEEP_R1, ST_SWEEP_R2:
        r = mk(ACT_MOVE, AXIS_HORIZ, 1'b1, c.sweep_speed, MOVE_ACCEL,
               c.sweep_pulses, 1'b0, 7'd0);
      ST_DROP_1, ST_DROP_2, ST_DROP_3:
        r = mk(ACT_MOVE, AXIS_VERT, 1'b1, c.vertical_speed, MOVE_ACCEL,
               c.short_drop_pulses, 1'b0, 7'd0);
      ST_RISE:
        r = mk(ACT_MOVE, AXIS_VERT, 1'b0, c.vertical_speed, MOVE_ACCEL,
               c.rise_pulses, 1'b0, 7'd0);
      default: r = mk(ACT_BOFF, AXIS_NONE, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, 7'd0);
    endcase
    return r;
  endfunction

  always_comb begin
    logic [16:0] tick_cnt;
    logic [1:0]  seen_t;
    logic        adv;
    tick_cnt  = {1'b0, ticks_r} + 17'd1;
    seen_t    = seen_r | {~vert_arrived, ~horiz_arrived};
    adv       = 1'b0;
    step_nxt  = step_r;
    seen_nxt  = seen_r;
    ticks_nxt = ticks_r;
    push.num  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      push.res[i] = mk(ACT_BOFF, AXIS_NONE, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, 7'd0);
    end

    case (command)
      CMD_TICK: begin
        if (step_r != ST_IDLE) begin
          if (tick_cnt > {1'b0, cfg.timeout_ticks}) begin
            // no progress for too long: abort and stop the brush
            step_nxt    = ST_IDLE;
            seen_nxt    = 2'b00;
            ticks_nxt   = 16'd0;
            push.num    = 2'd1;
          end else begin
            ticks_nxt = tick_cnt[15:0];
            case (step_r)
              ST_HOME: begin
                seen_nxt = seen_t;
                if (horiz_arrived && vert_arrived && seen_t == 2'b11) begin
                  step_nxt    = ST_IDLE;
                  seen_nxt    = 2'b00;
                  ticks_nxt   = 16'd0;
                  push.num    = 2'd2;
                  push.res[0] = mk(ACT_ZERO, AXIS_HORIZ, 1'b0, 13'd0, 8'd0, 24'd0,
                                   1'b0, 7'd0);
                  push.res[1] = mk(ACT_ZERO, AXIS_VERT, 1'b0, 13'd0, 8'd0, 24'd0,
                                   1'b0, 7'd0);
                end
              end
              ST_LONG_DROP, ST_DROP_1, ST_DROP_2, ST_DROP_3, ST_RISE: begin
                if (!vert_arrived) seen_nxt[1] = 1'b1;
                else if (seen_r[1]) adv = 1'b1;
              end
              ST_SWEEP_F1, ST_SWEEP_R1, ST_SWEEP_F2, ST_SWEEP_R2: begin
                if (!horiz_arrived) seen_nxt[0] = 1'b1;
                else if (seen_r[0]) adv = 1'b1;
              end
              ST_BRUSH_ON, ST_BRUSH_OFF: adv = 1'b1;
              default: adv = 1'b0;
            endcase
            if (adv) begin
              seen_nxt  = 2'b00;
              ticks_nxt = 16'd0;
              push.num  = 2'd1;
              if (step_r == ST_RISE) begin
                step_nxt    = ST_IDLE;
                push.res[0] = mk(ACT_DONE, AXIS_NONE, 1'b0, 13'd0, 8'd0, 24'd0,
                                 1'b0, 7'd0);
              end else begin
                step_nxt    = step_r + 4'd1;
                push.res[0] = issue(step_r + 4'd1, cfg);
              end
            end
          end
        end
      end
      CMD_START: begin
        if (step_r == ST_IDLE) begin
          step_nxt    = ST_LONG_DROP;
          seen_nxt    = 2'b00;
          ticks_nxt   = 16'd0;
          push.num    = 2'd1;
          push.res[0] = issue(ST_LONG_DROP, cfg);
        end
      end
      CMD_ESTOP: begin
        step_nxt    = ST_ESTOP;
        seen_nxt    = 2'b00;
        ticks_nxt   = 16'd0;
        push.num    = 2'd3;
        push.res[1] = mk(ACT_MOVE, AXIS_HORIZ, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, 7'd0);
        push.res[2] = mk(ACT_MOVE, AXIS_VERT, 1'b0, 13'd0, 8'd0, 24'd0, 1'b0, 7'd0);
      end
      default: begin
        if (step_r == ST_IDLE || step_r == ST_ESTOP) begin
          step_nxt    = ST_HOME;
          seen_nxt    = 2'b00;
          ticks_nxt   = 16'd0;
          push.num    = 2'd2;
          push.res[0] = mk(ACT_MOVE, AXIS_HORIZ, 1'b0, HOME_H_SPEED, MOVE_ACCEL,
                           cfg.home_offset, 1'b1, 7'd0);
          push.res[1] = mk(ACT_MOVE, AXIS_VERT, 1'b0, cfg.vertical_speed, MOVE_ACCEL,
                           24'd0, 1'b1, 7'd0);
        end
      end
    endcase

    for (int i = 0; i < 3; i++) begin
      push.res[i].step_now = step_nxt;
      push.res[i].last     = ((i + 1) == int'(push.num));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_IDLE;
      seen_r  <= 2'b00;
      ticks_r <= 16'd0;
    end else if (fire) begin
      step_r  <= step_nxt;
      seen_r  <= seen_nxt;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gms_result_fifo.sv -----
// gms_result_fifo: four-entry result queue, up to three pushes and one pop per cycle
// depends on gms_pkg for result_t and push_t
`default_nettype none

module gms_result_fifo
  import gms_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_en,
  input  wire push_t push,
  input  wire logic  pop,
  output logic       not_empty,
  output logic       room3,
  output result_t    head
);

  result_t     mem_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;
  logic [1:0]  num;
  logic        do_pop;

  assign num       = push_en ? push.num : 2'd0;
  assign do_pop    = pop && (count_r != 3'd0);
  assign not_empty = (count_r != 3'd0);
  // three free entries, whatever this cycle pops
  assign room3     = (count_r <= 3'd1);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (i < int'(num)) begin
        mem_r[wr_ptr_r + 2'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + num;
      rd_ptr_r <= rd_ptr_r + {1'b0, do_pop};
      count_r  <= count_r + {1'b0, num} - {2'd0, do_pop};
    end
  end

endmodule

`default_nettype wire
